// ===== design/efb_pkg.sv =====
// Shared types, codes and frame layout tables for the exception frame builder.
`default_nettype none

package efb_pkg;

  // Request command codes
  localparam logic [2:0] CMD_SHORT_BUS = 3'd0;
  localparam logic [2:0] CMD_LONG_BUS  = 3'd1;
  localparam logic [2:0] CMD_FRAME0    = 3'd2;
  localparam logic [2:0] CMD_FRAME2    = 3'd3;
  localparam logic [2:0] CMD_ILLEGAL   = 3'd4;
  localparam logic [2:0] CMD_PRIV      = 3'd5;

  // Result kind codes
  localparam logic [1:0] KIND_VECTOR = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_ABORT  = 2'd2;

  // Status word handling
  localparam logic [15:0] SR_SUPER = 16'h2000;
  localparam logic [15:0] SR_KEEP  = 16'h3FFF;

  // Special status word bits
  localparam logic [15:0] SSW_RERUN = 16'h0100;
  localparam logic [15:0] SSW_READ  = 16'h0040;

  // Frame format nibbles
  localparam logic [3:0] FMT_0 = 4'h0;
  localparam logic [3:0] FMT_2 = 4'h2;
  localparam logic [3:0] FMT_A = 4'hA;
  localparam logic [3:0] FMT_B = 4'hB;

  // Fixed vectors
  localparam logic [7:0] VEC_BUS_ERR = 8'd2;
  localparam logic [7:0] VEC_ILL     = 8'd4;
  localparam logic [7:0] VEC_PRIV    = 8'd8;
  localparam logic [7:0] VEC_LINE_A  = 8'd10;
  localparam logic [7:0] VEC_LINE_F  = 8'd11;
  localparam logic [3:0] OP_LINE_A   = 4'hA;
  localparam logic [3:0] OP_LINE_F   = 4'hF;

  // Push sizes in bytes
  localparam logic [2:0] SIZE_WORD = 3'd2;
  localparam logic [2:0] SIZE_LONG = 3'd4;

  localparam int unsigned IDX_W = 5;

  typedef enum logic [1:0] {
    FRM_0,
    FRM_2,
    FRM_A,
    FRM_B
  } frame_e;

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_FADDR,
    SRC_SSW,
    SRC_FMT,
    SRC_PC,
    SRC_NPC,
    SRC_SSR
  } push_src_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_PUSH
  } efb_state_e;

  typedef struct packed {
    push_src_e src;
    logic      long_sz;
    logic      last;
  } push_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic load_head;
    logic load_push;
  } efb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cmd_ok;
    logic abort;
    logic push_last;
    logic out_free;
  } efb_sts_t;

  function automatic push_t mk_push(push_src_e src, logic long_sz, logic last);
    push_t p;
    p.src     = src;
    p.long_sz = long_sz;
    p.last    = last;
    return p;
  endfunction

  // Frame layout: source and size of each push, in push order
  function automatic push_t frame_push(frame_e frm, logic [IDX_W-1:0] idx);
    push_t p;
    p = mk_push(SRC_ZERO, 1'b1, 1'b0);
    case (frm)
      FRM_0: begin
        case (idx)
          5'd0:    p = mk_push(SRC_FMT, 1'b0, 1'b0);
          5'd1:    p = mk_push(SRC_PC,  1'b1, 1'b0);
          5'd2:    p = mk_push(SRC_SSR, 1'b0, 1'b1);
          default: p = mk_push(SRC_ZERO, 1'b1, 1'b0);
        endcase
      end
      FRM_2: begin
        case (idx)
          5'd0:    p = mk_push(SRC_PC,  1'b1, 1'b0);
          5'd1:    p = mk_push(SRC_FMT, 1'b0, 1'b0);
          5'd2:    p = mk_push(SRC_NPC, 1'b1, 1'b0);
          5'd3:    p = mk_push(SRC_SSR, 1'b0, 1'b1);
          default: p = mk_push(SRC_ZERO, 1'b1, 1'b0);
        endcase
      end
      FRM_A: begin
        case (idx)
          5'd3:    p = mk_push(SRC_FADDR, 1'b1, 1'b0);
          5'd5:    p = mk_push(SRC_SSW,   1'b0, 1'b0);
          5'd6:    p = mk_push(SRC_ZERO,  1'b0, 1'b0);
          5'd7:    p = mk_push(SRC_FMT,   1'b0, 1'b0);
          5'd8:    p = mk_push(SRC_PC,    1'b1, 1'b0);
          5'd9:    p = mk_push(SRC_SSR,   1'b0, 1'b1);
          default: p = mk_push(SRC_ZERO,  1'b1, 1'b0);
        endcase
      end
      FRM_B: begin
        case (idx)
          5'd9, 5'd10: p = mk_push(SRC_ZERO, 1'b0, 1'b0);
          5'd19:   p = mk_push(SRC_FADDR, 1'b1, 1'b0);
          5'd21:   p = mk_push(SRC_SSW,   1'b0, 1'b0);
          5'd22:   p = mk_push(SRC_ZERO,  1'b0, 1'b0);
          5'd23:   p = mk_push(SRC_FMT,   1'b0, 1'b0);
          5'd24:   p = mk_push(SRC_PC,    1'b1, 1'b0);
          5'd25:   p = mk_push(SRC_SSR,   1'b0, 1'b1);
          default: p = mk_push(SRC_ZERO,  1'b1, 1'b0);
        endcase
      end
      default: p = mk_push(SRC_ZERO, 1'b1, 1'b0);
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== design/exception_frame_builder.sv =====
// Top level of the exception frame builder: controller plus datapath.
//
// One input request describes an exception. The block answers with a run of
// results on the output channel: first the vector fetch address
// (vector base plus four times the vector), then one stack write per push,
// each lowering the stack pointer by 2 or 4 bytes. last marks the end of the
// run. A bus error with suppress set gives a single abort-only result.
// Command codes 6 and 7 are taken and produce nothing.
// Both channels use valid/stall; a request moves when valid is high and
// stall low. The vector base register is written with cfg_we_i/cfg_wdata_i.
// The request is captured, then the vector result is loaded into the output
// register once that register is free. Results then follow one per cycle while
// the receiver does not stall. A new request is taken only after the last
// result of the run has been loaded.
// A stalled result holds in the output register and the run pauses.
// Reset clears the vector base to zero and empties the output register.
`default_nettype none

module exception_frame_builder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [31:0] fault_address_i,
  input  wire logic        fault_write_i,
  input  wire logic [2:0]  function_code_i,
  input  wire logic [15:0] saved_status_i,
  input  wire logic [15:0] current_status_i,
  input  wire logic [31:0] fault_pc_i,
  input  wire logic [31:0] next_pc_i,
  input  wire logic [7:0]  vector_number_i,
  input  wire logic [15:0] opcode_i,
  input  wire logic [31:0] stack_pointer_i,
  input  wire logic        suppress_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [31:0]      address_o,
  output logic [31:0]      data_o,
  output logic [2:0]       size_bytes_o,
  output logic [15:0]      new_status_word_o,
  output logic [31:0]      new_stack_pointer_o,
  output logic             last_o
);
  import efb_pkg::*;

  efb_cmd_t cmd;
  efb_sts_t sts;

  // Sequence the run
  efb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Build each result
  efb_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .command_i           (command_i),
    .fault_address_i     (fault_address_i),
    .fault_write_i       (fault_write_i),
    .function_code_i     (function_code_i),
    .saved_status_i      (saved_status_i),
    .current_status_i    (current_status_i),
    .fault_pc_i          (fault_pc_i),
    .next_pc_i           (next_pc_i),
    .vector_number_i     (vector_number_i),
    .opcode_i            (opcode_i),
    .stack_pointer_i     (stack_pointer_i),
    .suppress_i          (suppress_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .kind_o              (kind_o),
    .address_o           (address_o),
    .data_o              (data_o),
    .size_bytes_o        (size_bytes_o),
    .new_status_word_o   (new_status_word_o),
    .new_stack_pointer_o (new_stack_pointer_o),
    .last_o              (last_o)
  );

endmodule

`default_nettype wire

// ===== design/efb_ctrl.sv =====
// Controller state machine that sequences the head result and the stack pushes.
`default_nettype none

module efb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire efb_pkg::efb_sts_t sts_i,
  output efb_pkg::efb_cmd_t      cmd_o
);
  import efb_pkg::*;

  efb_state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Decide next state and issue datapath commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && sts_i.cmd_ok) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_head = 1'b1;
          state_d         = sts_i.abort ? ST_IDLE : ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.load_push = 1'b1;
          if (sts_i.push_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/efb_datapath.sv =====
// Datapath: request capture, vector base register, stack pointer and output register.
`default_nettype none

module efb_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [31:0]       cfg_wdata_i,
  input  wire logic [2:0]        command_i,
  input  wire logic [31:0]       fault_address_i,
  input  wire logic              fault_write_i,
  input  wire logic [2:0]        function_code_i,
  input  wire logic [15:0]       saved_status_i,
  input  wire logic [15:0]       current_status_i,
  input  wire logic [31:0]       fault_pc_i,
  input  wire logic [31:0]       next_pc_i,
  input  wire logic [7:0]        vector_number_i,
  input  wire logic [15:0]       opcode_i,
  input  wire logic [31:0]       stack_pointer_i,
  input  wire logic              suppress_i,
  input  wire efb_pkg::efb_cmd_t cmd_i,
  output efb_pkg::efb_sts_t      sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [1:0]             kind_o,
  output logic [31:0]            address_o,
  output logic [31:0]            data_o,
  output logic [2:0]             size_bytes_o,
  output logic [15:0]            new_status_word_o,
  output logic [31:0]            new_stack_pointer_o,
  output logic                   last_o
);
  import efb_pkg::*;

  logic [31:0]      vbr_q;
  logic             out_valid_q;

  // Captured request
  frame_e           frame_q, frame_d;
  logic [7:0]       vec_q, vec_d;
  logic             abort_q, abort_d;
  logic             cmd_ok;
  logic [31:0]      faddr_q, pc_q, npc_q, sp_q, sp_d;
  logic [15:0]      ssw_q, ssr_q, csr_q;
  logic [IDX_W-1:0] idx_q, idx_d;

  // Output register
  logic [1:0]       kind_q, kind_d;
  logic [31:0]      addr_q, addr_d, data_q, data_d, nsp_q, nsp_d;
  logic [2:0]       size_q, size_d;
  logic [15:0]      nsw_q, nsw_d;
  logic             last_q, last_d;

  push_t            push;
  logic [31:0]      push_val;
  logic [15:0]      fmt_word;
  logic [15:0]      status_sv;
  logic [2:0]       push_size;
  logic [31:0]      sp_push;

  // Decode the incoming command into frame layout and vector
  always_comb begin
    frame_d = FRM_0;
    vec_d   = vector_number_i;
    abort_d = 1'b0;
    cmd_ok  = 1'b1;
    unique case (command_i)
      CMD_SHORT_BUS: begin
        frame_d = FRM_A;
        vec_d   = VEC_BUS_ERR;
        abort_d = suppress_i;
      end
      CMD_LONG_BUS: begin
        frame_d = FRM_B;
        vec_d   = VEC_BUS_ERR;
        abort_d = suppress_i;
      end
      CMD_FRAME0: frame_d = FRM_0;
      CMD_FRAME2: frame_d = FRM_2;
      CMD_ILLEGAL: begin
        if (opcode_i[15:12] == OP_LINE_A) begin
          vec_d = VEC_LINE_A;
        end else if (opcode_i[15:12] == OP_LINE_F) begin
          vec_d = VEC_LINE_F;
        end else begin
          vec_d = VEC_ILL;
        end
      end
      CMD_PRIV: vec_d = VEC_PRIV;
      default: cmd_ok = 1'b0;
    endcase
  end

  // Write the vector base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbr_q <= '0;
    end else if (cfg_we_i) begin
      vbr_q <= cfg_wdata_i;
    end
  end

  // Capture the request fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      frame_q <= frame_d;
      vec_q   <= vec_d;
      abort_q <= abort_d;
      faddr_q <= fault_address_i;
      pc_q    <= fault_pc_i;
      npc_q   <= next_pc_i;
      ssr_q   <= saved_status_i;
      csr_q   <= current_status_i;
      ssw_q   <= SSW_RERUN | (fault_write_i ? 16'h0000 : SSW_READ) | {13'b0, function_code_i};
    end
  end

  // Look up the current push and select its value
  assign push      = frame_push(frame_q, idx_q);
  assign status_sv = (csr_q | SR_SUPER) & SR_KEEP;
  assign push_size = push.long_sz ? SIZE_LONG : SIZE_WORD;
  assign sp_push   = sp_q - {29'b0, push_size};

  always_comb begin
    unique case (frame_q)
      FRM_0:   fmt_word = {FMT_0, 2'b00, vec_q, 2'b00};
      FRM_2:   fmt_word = {FMT_2, 2'b00, vec_q, 2'b00};
      FRM_A:   fmt_word = {FMT_A, 2'b00, vec_q, 2'b00};
      FRM_B:   fmt_word = {FMT_B, 2'b00, vec_q, 2'b00};
      default: fmt_word = '0;
    endcase
  end

  always_comb begin
    case (push.src)
      SRC_FADDR: push_val = faddr_q;
      SRC_SSW:   push_val = {16'b0, ssw_q};
      SRC_FMT:   push_val = {16'b0, fmt_word};
      SRC_PC:    push_val = pc_q;
      SRC_NPC:   push_val = npc_q;
      SRC_SSR:   push_val = {16'b0, ssr_q};
      default:   push_val = '0;
    endcase
  end

  // Advance the stack pointer and push index
  always_comb begin
    sp_d  = sp_q;
    idx_d = idx_q;
    if (cmd_i.capture) begin
      sp_d  = stack_pointer_i;
      idx_d = '0;
    end else if (cmd_i.load_push) begin
      sp_d  = sp_push;
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    sp_q  <= sp_d;
    idx_q <= idx_d;
  end

  // Form the next result
  always_comb begin
    kind_d = kind_q;
    addr_d = addr_q;
    data_d = data_q;
    size_d = size_q;
    nsw_d  = nsw_q;
    nsp_d  = nsp_q;
    last_d = last_q;
    if (cmd_i.load_head) begin
      data_d = '0;
      size_d = '0;
      nsp_d  = sp_q;
      if (abort_q) begin
        kind_d = KIND_ABORT;
        addr_d = '0;
        nsw_d  = csr_q;
        last_d = 1'b1;
      end else begin
        kind_d = KIND_VECTOR;
        addr_d = vbr_q + {22'b0, vec_q, 2'b00};
        nsw_d  = status_sv;
        last_d = 1'b0;
      end
    end else if (cmd_i.load_push) begin
      kind_d = KIND_WRITE;
      addr_d = sp_push;
      data_d = push.long_sz ? push_val : {16'b0, push_val[15:0]};
      size_d = push_size;
      nsw_d  = status_sv;
      nsp_d  = sp_push;
      last_d = push.last;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    addr_q <= addr_d;
    data_q <= data_d;
    size_q <= size_d;
    nsw_q  <= nsw_d;
    nsp_q  <= nsp_d;
    last_q <= last_d;
  end

  // Set valid on load, drop it once the result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_head || cmd_i.load_push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.cmd_ok    = cmd_ok;
  assign sts_o.abort     = abort_q;
  assign sts_o.push_last = push.last;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o         = out_valid_q;
  assign kind_o              = kind_q;
  assign address_o           = addr_q;
  assign data_o              = data_q;
  assign size_bytes_o        = size_q;
  assign new_status_word_o   = nsw_q;
  assign new_stack_pointer_o = nsp_q;
  assign last_o              = last_q;

endmodule

`default_nettype wire

// ===== bench/exception_frame_builder_test.sv =====
// Self-checking testbench for the exception frame builder: directed table plus random requests.
`default_nettype none

module exception_frame_builder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import efb_pkg::*;

  // Command codes the block takes and drops
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int N_DIR        = 22;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 90;
  localparam int DRAIN_CYCLES = 8;
  localparam int END_CYCLES   = 40;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] fault_address;
    logic        fault_write;
    logic [2:0]  function_code;
    logic [15:0] saved_status;
    logic [15:0] current_status;
    logic [31:0] fault_pc;
    logic [31:0] next_pc;
    logic [7:0]  vector_number;
    logic [15:0] opcode;
    logic [31:0] stack_pointer;
    logic        suppress;
  } exc_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] data;
    logic [2:0]  size_bytes;
    logic [15:0] status_word;
    logic [31:0] stack_ptr;
    logic        last;
  } frame_res_t;

  // First result of a run, typed in by hand (data and size are zero)
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [15:0] status_word;
    logic [31:0] stack_ptr;
    logic        last;
  } head_res_t;

  typedef struct packed {
    logic        set_base;
    logic [31:0] base;
    exc_req_t    req;
    logic        check_head;
    head_res_t   head;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  command_i = '0;
  logic [31:0] fault_address_i = '0;
  logic        fault_write_i = 1'b0;
  logic [2:0]  function_code_i = '0;
  logic [15:0] saved_status_i = '0;
  logic [15:0] current_status_i = '0;
  logic [31:0] fault_pc_i = '0;
  logic [31:0] next_pc_i = '0;
  logic [7:0]  vector_number_i = '0;
  logic [15:0] opcode_i = '0;
  logic [31:0] stack_pointer_i = '0;
  logic        suppress_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [31:0] address_o;
  logic [31:0] data_o;
  logic [2:0]  size_bytes_o;
  logic [15:0] new_status_word_o;
  logic [31:0] new_stack_pointer_o;
  logic        last_o;

  // Predictor state
  logic [31:0] vbr_model = '0;
  logic [31:0] frame_sp;
  logic [15:0] frame_sw;
  frame_res_t  frame_q [$];
  frame_res_t  seen_res;
  frame_res_t  want_res;

  int err_cnt    = 0;
  int result_cnt = 0;
  int cycle_cnt  = 0;

  exception_frame_builder u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .command_i           (command_i),
    .fault_address_i     (fault_address_i),
    .fault_write_i       (fault_write_i),
    .function_code_i     (function_code_i),
    .saved_status_i      (saved_status_i),
    .current_status_i    (current_status_i),
    .fault_pc_i          (fault_pc_i),
    .next_pc_i           (next_pc_i),
    .vector_number_i     (vector_number_i),
    .opcode_i            (opcode_i),
    .stack_pointer_i     (stack_pointer_i),
    .suppress_i          (suppress_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .kind_o              (kind_o),
    .address_o           (address_o),
    .data_o              (data_o),
    .size_bytes_o        (size_bytes_o),
    .new_status_word_o   (new_status_word_o),
    .new_stack_pointer_o (new_stack_pointer_o),
    .last_o              (last_o)
  );

  // Generate the clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Format nibble on top, vector offset in the low bits
  function automatic logic [15:0] fmt_vec_word(logic [3:0] fmt, logic [7:0] vec);
    return {fmt, 12'h000} | {6'h00, vec, 2'b00};
  endfunction

  // Lower the stack pointer and queue one stack write
  function automatic void queue_push(logic [31:0] value, logic [2:0] len, logic fin);
    frame_res_t e;
    frame_sp      = frame_sp - {29'h0, len};
    e.kind        = KIND_WRITE;
    e.address     = frame_sp;
    e.data        = (len == SIZE_WORD) ? {16'h0000, value[15:0]} : value;
    e.size_bytes  = len;
    e.status_word = frame_sw;
    e.stack_ptr   = frame_sp;
    e.last        = fin;
    frame_q.push_back(e);
  endfunction

  // Queue the whole run of results that one request causes
  function automatic void predict_frame(exc_req_t r, logic use_head, head_res_t h);
    frame_res_t  e;
    logic [7:0]  vec;
    logic [15:0] ssw;
    if (r.command > CMD_PRIV) return;
    e.data       = '0;
    e.size_bytes = '0;
    // Suppressed bus error: abort only, status untouched
    if (r.command <= CMD_LONG_BUS && r.suppress) begin
      e.kind        = KIND_ABORT;
      e.address     = '0;
      e.status_word = r.current_status;
      e.stack_ptr   = r.stack_pointer;
      e.last        = 1'b1;
    end else begin
      frame_sw = (r.current_status | SR_SUPER) & SR_KEEP;
      ssw      = SSW_RERUN | (r.fault_write ? 16'h0000 : SSW_READ) | {13'h0, r.function_code};
      case (r.command)
        CMD_SHORT_BUS, CMD_LONG_BUS: vec = VEC_BUS_ERR;
        CMD_FRAME0, CMD_FRAME2:      vec = r.vector_number;
        CMD_ILLEGAL: begin
          case (r.opcode[15:12])
            OP_LINE_A: vec = VEC_LINE_A;
            OP_LINE_F: vec = VEC_LINE_F;
            default:   vec = VEC_ILL;
          endcase
        end
        default: vec = VEC_PRIV;
      endcase
      e.kind        = KIND_VECTOR;
      e.address     = vbr_model + {22'h0, vec, 2'b00};
      e.status_word = frame_sw;
      e.stack_ptr   = r.stack_pointer;
      e.last        = 1'b0;
    end
    if (use_head) begin
      e.kind        = h.kind;
      e.address     = h.address;
      e.status_word = h.status_word;
      e.stack_ptr   = h.stack_ptr;
      e.last        = h.last;
    end
    frame_q.push_back(e);
    if (e.kind == KIND_ABORT) return;

    // Stack pushes in frame order
    frame_sp = r.stack_pointer;
    case (r.command)
      CMD_SHORT_BUS: begin
        for (int i = 0; i < 3; i++) queue_push('0, SIZE_LONG, 1'b0);
        queue_push(r.fault_address, SIZE_LONG, 1'b0);
        queue_push('0, SIZE_LONG, 1'b0);
        queue_push({16'h0, ssw}, SIZE_WORD, 1'b0);
        queue_push('0, SIZE_WORD, 1'b0);
        queue_push({16'h0, fmt_vec_word(FMT_A, vec)}, SIZE_WORD, 1'b0);
        queue_push(r.fault_pc, SIZE_LONG, 1'b0);
        queue_push({16'h0, r.saved_status}, SIZE_WORD, 1'b1);
      end
      CMD_LONG_BUS: begin
        for (int i = 0; i < 9; i++) queue_push('0, SIZE_LONG, 1'b0);
        queue_push('0, SIZE_WORD, 1'b0);
        queue_push('0, SIZE_WORD, 1'b0);
        for (int i = 0; i < 8; i++) queue_push('0, SIZE_LONG, 1'b0);
        queue_push(r.fault_address, SIZE_LONG, 1'b0);
        queue_push('0, SIZE_LONG, 1'b0);
        queue_push({16'h0, ssw}, SIZE_WORD, 1'b0);
        queue_push('0, SIZE_WORD, 1'b0);
        queue_push({16'h0, fmt_vec_word(FMT_B, vec)}, SIZE_WORD, 1'b0);
        queue_push(r.fault_pc, SIZE_LONG, 1'b0);
        queue_push({16'h0, r.saved_status}, SIZE_WORD, 1'b1);
      end
      CMD_FRAME2: begin
        queue_push(r.fault_pc, SIZE_LONG, 1'b0);
        queue_push({16'h0, fmt_vec_word(FMT_2, vec)}, SIZE_WORD, 1'b0);
        queue_push(r.next_pc, SIZE_LONG, 1'b0);
        queue_push({16'h0, r.saved_status}, SIZE_WORD, 1'b1);
      end
      default: begin
        queue_push({16'h0, fmt_vec_word(FMT_0, vec)}, SIZE_WORD, 1'b0);
        queue_push(r.fault_pc, SIZE_LONG, 1'b0);
        queue_push({16'h0, r.saved_status}, SIZE_WORD, 1'b1);
      end
    endcase
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_cnt < 40)
      $display("mismatch at result %0d: %s got %h want %h", result_cnt, what, got, want);
    err_cnt++;
  endtask

  // Present one request and hold it until taken, then predict its results
  task automatic drive_req(input exc_req_t r, input logic use_head, input head_res_t h);
    in_valid_i       <= 1'b1;
    command_i        <= r.command;
    fault_address_i  <= r.fault_address;
    fault_write_i    <= r.fault_write;
    function_code_i  <= r.function_code;
    saved_status_i   <= r.saved_status;
    current_status_i <= r.current_status;
    fault_pc_i       <= r.fault_pc;
    next_pc_i        <= r.next_pc;
    vector_number_i  <= r.vector_number;
    opcode_i         <= r.opcode;
    stack_pointer_i  <= r.stack_pointer;
    suppress_i       <= r.suppress;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_frame(r, use_head, h);
  endtask

  // Drain the block, then write the vector base
  task automatic write_base(input logic [31:0] value);
    in_valid_i <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    vbr_model = value;
    cfg_we_i <= 1'b0;
  endtask

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_res = '{kind_o, address_o, data_o, size_bytes_o, new_status_word_o,
                   new_stack_pointer_o, last_o};
      if (frame_q.size() == 0) begin
        report_mismatch("unexpected result, address", seen_res.address, '0);
      end else begin
        want_res = frame_q.pop_front();
        if (seen_res.kind != want_res.kind)
          report_mismatch("kind", 32'(seen_res.kind), 32'(want_res.kind));
        if (seen_res.address != want_res.address)
          report_mismatch("address", seen_res.address, want_res.address);
        if (seen_res.data != want_res.data)
          report_mismatch("data", seen_res.data, want_res.data);
        if (seen_res.size_bytes != want_res.size_bytes)
          report_mismatch("size_bytes", 32'(seen_res.size_bytes),
                          32'(want_res.size_bytes));
        if (seen_res.status_word != want_res.status_word)
          report_mismatch("new_status_word", 32'(seen_res.status_word),
                          32'(want_res.status_word));
        if (seen_res.stack_ptr != want_res.stack_ptr)
          report_mismatch("new_stack_pointer", seen_res.stack_ptr, want_res.stack_ptr);
        if (seen_res.last != want_res.last)
          report_mismatch("last", 32'(seen_res.last), 32'(want_res.last));
      end
      result_cnt++;
    end
  end

  // Stall the result channel in stretches of changing character
  initial begin
    int mode;
    int len;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 80);
      repeat (len) begin
        @(posedge clk_i);
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 1) == 0);
          2:       out_stall_i <= (cycle_cnt % 3 == 0);
          default: out_stall_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_tab [N_DIR];
    exc_req_t  req;
    head_res_t no_head;
    int        counted;
    int        burst;
    int        gap;

    no_head = '0;

    // Directed table: base write, request, optional typed first result
    dir_tab[0]  = '{1'b0, 32'h0, '{CMD_SHORT_BUS, 32'hFFFF_FFFF, 1'b0, 3'd7, 16'hFFFF,
                    16'hFFFF, 32'h0, 32'h0, 8'h00, 16'h0000, 32'h0000_1000, 1'b0},
                    1'b1, '{KIND_VECTOR, 32'h8, 16'h3FFF, 32'h0000_1000, 1'b0}};
    dir_tab[1]  = '{1'b0, 32'h0, '{CMD_LONG_BUS, 32'h0, 1'b1, 3'd0, 16'h0000, 16'h0000,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'h0000_2000, 1'b0},
                    1'b1, '{KIND_VECTOR, 32'h8, 16'h2000, 32'h0000_2000, 1'b0}};
    dir_tab[2]  = '{1'b0, 32'h0, '{CMD_SHORT_BUS, 32'h1234_5678, 1'b1, 3'd5, 16'h2700,
                    16'hC123, 32'h0000_4000, 32'h0, 8'h00, 16'h0000, 32'h0000_3000, 1'b1},
                    1'b1, '{KIND_ABORT, 32'h0, 16'hC123, 32'h0000_3000, 1'b1}};
    dir_tab[3]  = '{1'b0, 32'h0, '{CMD_LONG_BUS, 32'hFFFF_FFFF, 1'b0, 3'd2, 16'hFFFF,
                    16'hFFFF, 32'h0, 32'h0, 8'h00, 16'h0000, 32'hFFFF_FFFF, 1'b1},
                    1'b1, '{KIND_ABORT, 32'h0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1}};
    dir_tab[4]  = '{1'b0, 32'h0, '{CMD_FRAME0, 32'h0, 1'b0, 3'd0, 16'h0000, 16'h8000,
                    32'h0000_1234, 32'h0, 8'h00, 16'h0000, 32'h0000_0400, 1'b0},
                    1'b1, '{KIND_VECTOR, 32'h0, 16'h2000, 32'h0000_0400, 1'b0}};
    dir_tab[5]  = '{1'b0, 32'h0, '{CMD_FRAME0, 32'h0, 1'b0, 3'd0, 16'hFFFF, 16'h4000,
                    32'hFFFF_FFFF, 32'h0, 8'hFF, 16'h0000, 32'h0000_0400, 1'b0},
                    1'b1, '{KIND_VECTOR, 32'h3FC, 16'h2000, 32'h0000_0400, 1'b0}};
    dir_tab[6]  = '{1'b0, 32'h0, '{CMD_FRAME2, 32'h0, 1'b0, 3'd0, 16'hFFFF, 16'h1FFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'h0000, 32'h0000_0800, 1'b0},
                    1'b1, '{KIND_VECTOR, 32'h3FC, 16'h3FFF, 32'h0000_0800, 1'b0}};
    dir_tab[7]  = '{1'b0, 32'h0, '{CMD_FRAME2, 32'h0, 1'b0, 3'd0, 16'hA5A5, 16'h5A5A,
                    32'h0001_0002, 32'h0001_0006, 8'h5A, 16'h0000, 32'h8000_0000, 1'b0},
                    1'b0, no_head};
    dir_tab[8]  = '{1'b0, 32'h0, '{CMD_ILLEGAL, 32'h0, 1'b0, 3'd0, 16'h0000, 16'h0000,
                    32'h0000_0100, 32'h0, 8'h00, 16'hA123, 32'h0000_1000, 1'b0},
                    1'b1, '{KIND_VECTOR, 32'h28, 16'h2000, 32'h0000_1000, 1'b0}};
    dir_tab[9]  = '{1'b0, 32'h0, '{CMD_ILLEGAL, 32'h0, 1'b0, 3'd0, 16'h0000, 16'h0000,
                    32'h0000_0100, 32'h0, 8'h00, 16'hF000, 32'h0000_1000, 1'b0},
                    1'b1, '{KIND_VECTOR, 32'h2C, 16'h2000, 32'h0000_1000, 1'b0}};
    dir_tab[10] = '{1'b0, 32'h0, '{CMD_ILLEGAL, 32'h0, 1'b0, 3'd0, 16'h0000, 16'h0000,
                    32'h0000_0100, 32'h0, 8'h00, 16'h0FFF, 32'h0000_1000, 1'b0},
                    1'b1, '{KIND_VECTOR, 32'h10, 16'h2000, 32'h0000_1000, 1'b0}};
    dir_tab[11] = '{1'b0, 32'h0, '{CMD_ILLEGAL, 32'h0, 1'b0, 3'd0, 16'h0000, 16'h0000,
                    32'h0000_0100, 32'h0, 8'h00, 16'h7ABC, 32'h0000_1000, 1'b0},
                    1'b1, '{KIND_VECTOR, 32'h10, 16'h2000, 32'h0000_1000, 1'b0}};
    dir_tab[12] = '{1'b0, 32'h0, '{CMD_PRIV, 32'h0, 1'b0, 3'd0, 16'h0000, 16'h0000,
                    32'h0000_0200, 32'h0, 8'h00, 16'h0000, 32'h0000_1000, 1'b0},
                    1'b1, '{KIND_VECTOR, 32'h20, 16'h2000, 32'h0000_1000, 1'b0}};
    // Suppress is ignored outside bus errors
    dir_tab[13] = '{1'b0, 32'h0, '{CMD_PRIV, 32'h0, 1'b0, 3'd0, 16'h0000, 16'h0000,
                    32'h0000_0200, 32'h0, 8'h00, 16'h0000, 32'h0000_1000, 1'b1},
                    1'b1, '{KIND_VECTOR, 32'h20, 16'h2000, 32'h0000_1000, 1'b0}};
    dir_tab[14] = '{1'b0, 32'h0, '{CMD_ILLEGAL, 32'h0, 1'b0, 3'd0, 16'h0000, 16'h0000,
                    32'h0000_0200, 32'h0, 8'h00, 16'hA000, 32'h0000_1000, 1'b1},
                    1'b1, '{KIND_VECTOR, 32'h28, 16'h2000, 32'h0000_1000, 1'b0}};
    // Spare command codes give nothing
    dir_tab[15] = '{1'b0, 32'h0, '{CMD_SPARE_6, 32'hFFFF_FFFF, 1'b1, 3'd7, 16'hFFFF,
                    16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'h0, 1'b1},
                    1'b0, no_head};
    dir_tab[16] = '{1'b0, 32'h0, '{CMD_SPARE_7, 32'h0, 1'b0, 3'd0, 16'h0000, 16'h0000,
                    32'h0, 32'h0, 8'h00, 16'h0000, 32'h0, 1'b0}, 1'b0, no_head};
    // Stack pointer wraps below zero
    dir_tab[17] = '{1'b0, 32'h0, '{CMD_FRAME0, 32'h0, 1'b0, 3'd0, 16'h1234, 16'h0700,
                    32'hDEAD_BEEF, 32'h0, 8'h40, 16'h0000, 32'h0000_0002, 1'b0},
                    1'b0, no_head};
    // Vector address wraps past the top of memory
    dir_tab[18] = '{1'b1, 32'hFFFF_FFFF, '{CMD_FRAME0, 32'h0, 1'b0, 3'd0, 16'h0000,
                    16'h0000, 32'h0, 32'h0, 8'h01, 16'h0000, 32'h0000_1000, 1'b0},
                    1'b1, '{KIND_VECTOR, 32'h3, 16'h2000, 32'h0000_1000, 1'b0}};
    dir_tab[19] = '{1'b0, 32'h0, '{CMD_SHORT_BUS, 32'h0000_0010, 1'b1, 3'd1, 16'h0000,
                    16'h0000, 32'h0, 32'h0, 8'h00, 16'h0000, 32'h0, 1'b0},
                    1'b1, '{KIND_VECTOR, 32'h7, 16'h2000, 32'h0, 1'b0}};
    dir_tab[20] = '{1'b1, 32'h8000_0000, '{CMD_LONG_BUS, 32'h8765_4321, 1'b0, 3'd6,
                    16'h0000, 16'h0000, 32'h0, 32'h0, 8'h00, 16'h0000, 32'h10, 1'b0},
                    1'b1, '{KIND_VECTOR, 32'h8000_0008, 16'h2000, 32'h10, 1'b0}};
    dir_tab[21] = '{1'b1, 32'h1234_5678, '{CMD_FRAME2, 32'h0, 1'b0, 3'd0, 16'hBEEF,
                    16'hCAFE, 32'h0000_2000, 32'h0000_2004, 8'h10, 16'h0000, 32'h0000_5000,
                    1'b0}, 1'b0, no_head};

    // Hold reset, then release it
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].set_base) write_base(dir_tab[i].base);
      drive_req(dir_tab[i].req, dir_tab[i].check_head, dir_tab[i].head);
    end

    // Random phases, each with its own vector base
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       write_base(32'hFFFF_FFFF);
        1:       write_base(32'h0);
        2:       write_base(32'hFFFF_FC00);
        default: write_base($urandom);
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          req.command = ($urandom_range(0, 99) < 6) ?
                        (($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7) :
                        3'($urandom_range(0, 5));
          req.fault_address  = $urandom;
          req.fault_write    = 1'($urandom);
          req.function_code  = 3'($urandom);
          req.saved_status   = 16'($urandom);
          req.current_status = 16'($urandom);
          req.fault_pc       = $urandom;
          req.next_pc        = $urandom;
          req.vector_number  = 8'($urandom);
          req.opcode         = 16'($urandom);
          case ($urandom_range(0, 2))
            0:       req.opcode[15:12] = OP_LINE_A;
            1:       req.opcode[15:12] = OP_LINE_F;
            default: ;
          endcase
          req.stack_pointer  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom;
          req.suppress       = ($urandom_range(0, 3) == 0);
          drive_req(req, 1'b0, no_head);
          if (req.command <= CMD_PRIV) counted++;
        end
        // Idle between bursts, sometimes not at all
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    // Drain and finish
    write_base($urandom);
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);
    if (frame_q.size() != 0) report_mismatch("results never seen", frame_q.size(), 0);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
